// ===== hdl/pfba_pkg.sv =====
// Package with sizes, codes and state type of the page frame bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
package pfba_pkg;
  localparam int NUM_FRAMES  = 4096;
  localparam int PAGE_SHIFT  = 12;
  localparam int MAX_RUN     = 256;
  localparam int WORD_BITS   = 32;
  localparam int WORD_SHIFT  = 5;
  localparam int NUM_WORDS   = NUM_FRAMES / WORD_BITS;
  localparam int WADDR_W     = $clog2(NUM_WORDS);
  localparam int FRAME_W     = $clog2(NUM_FRAMES);
  localparam int COUNT_W     = FRAME_W + 1;

  localparam logic [1:0] MODE_FREE  = 2'd0;
  localparam logic [1:0] MODE_USED  = 2'd1;
  localparam logic [1:0] MODE_ALLOC = 2'd2;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_SRD, ST_SCHK, ST_MRD, ST_MWR
  } pfba_state_t;
endpackage
`default_nettype wire

// ===== hdl/page_frame_bitmap_allocator.sv =====
// Top level of the page frame bitmap allocator: usage map memory and its sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Usage map is a 128 x 32-bit synchronous memory read and written one word at a time.
// After reset a clearing pass marks every frame used; busy stays high.
// Region ops read then write each map word touched; a free then also marks frame 0 used in a
// fixup pass. Allocation reads a word and checks it a byte at a time (skipping a fully used
// word at once) up to the limit, then marks the run per word. A result appears on out_valid for
// exactly one cycle; the receiver cannot stall, and the next start is taken once busy is low.
module page_frame_bitmap_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [31:0]                   in_region_address,
  input  wire logic [31:0]                   in_region_length,
  input  wire logic [8:0]                    in_run_frames,
  input  wire logic                          cfg_we,
  input  wire logic [pfba_pkg::COUNT_W-1:0]  cfg_wdata,
  output logic                               out_valid,
  output logic                               out_granted,
  output logic [23:0]                        out_run_address,
  output logic [pfba_pkg::COUNT_W-1:0]       out_frames_in_use
);
  import pfba_pkg::*;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] mem_q_r;
  logic                 mem_we, mem_re;
  logic [WADDR_W-1:0]   mem_wa, mem_ra;
  logic [WORD_BITS-1:0] mem_wd;

  pfba_state_t          state_r, state_nxt;
  logic [COUNT_W-1:0]   maxf_r;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic [WADDR_W-1:0]   w_r, w_nxt;
  logic [1:0]           sub_r, sub_nxt;
  logic [8:0]           run_r, run_nxt;
  logic [8:0]           size_r, size_nxt;
  logic [COUNT_W-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic                 val_r, val_nxt, fix0_r, fix0_nxt;
  logic [23:0]          raddr_r, raddr_nxt;
  logic                 ov_r, ov_nxt, og_r, og_nxt;
  logic [23:0]          oa_r, oa_nxt;

  logic [COUNT_W-1:0]   lim;
  logic [19:0]          first;
  logic [20:0]          endf;
  logic [COUNT_W-1:0]   endc, kf;
  logic                 nonempty;
  logic [COUNT_W:0]     sum;
  logic [8:0]           run_v;
  logic                 hit, stop;
  logic [FRAME_W-1:0]   hit_f, fb;
  logic [COUNT_W-1:0]   hit_lo;
  logic [WORD_BITS-1:0] msk;

  assign lim = (maxf_r > COUNT_W'(NUM_FRAMES)) ? COUNT_W'(NUM_FRAMES) : maxf_r;
  assign first = in_region_address[31:PAGE_SHIFT];
  assign endf = {1'b0, first} + {1'b0, in_region_length[31:PAGE_SHIFT]};
  assign endc = (endf > {8'd0, lim}) ? lim : endf[COUNT_W-1:0];
  assign nonempty = {7'd0, endc} > first;
  assign kf = endc - first[COUNT_W-1:0];

  always_comb begin
    run_v = run_r;
    hit = 1'b0;
    stop = 1'b0;
    hit_f = '0;
    fb = '0;
    for (int j = 0; j < 8; j++) begin
      fb = {w_r, sub_r, 3'(j)};
      if (!hit && !stop) begin
        if ({1'b0, fb} >= lim) begin
          stop = 1'b1;
        end else if (mem_q_r[{sub_r, 3'(j)}]) begin
          run_v = '0;
        end else begin
          run_v = run_v + 9'd1;
          if (run_v == size_r) begin
            hit = 1'b1;
            hit_f = fb;
          end
        end
      end
    end
    hit_lo = {1'b0, hit_f} + COUNT_W'(1) - {4'd0, size_r};
    for (int j = 0; j < WORD_BITS; j++) begin
      msk[j] = ({1'b0, w_r, 5'(j)} >= lo_r) && ({1'b0, w_r, 5'(j)} < hi_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    w_nxt = w_r;
    sub_nxt = sub_r;
    run_nxt = run_r;
    size_nxt = size_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    val_nxt = val_r;
    fix0_nxt = fix0_r;
    raddr_nxt = raddr_r;
    ov_nxt = 1'b0;
    og_nxt = og_r;
    oa_nxt = oa_r;
    mem_we = 1'b0;
    mem_wa = w_r;
    mem_wd = '1;
    mem_re = 1'b0;
    mem_ra = w_r;
    sum = '0;
    unique case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        w_nxt = w_r + WADDR_W'(1);
        if (w_r == WADDR_W'(NUM_WORDS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          raddr_nxt = '0;
          size_nxt = in_run_frames;
          case (in_mode) inside
            MODE_FREE, MODE_USED: begin
              val_nxt = (in_mode == MODE_USED);
              fix0_nxt = (in_mode == MODE_FREE) && nonempty;
              if (nonempty) begin
                lo_nxt = first[COUNT_W-1:0];
                hi_nxt = endc;
                w_nxt = first[FRAME_W-1:WORD_SHIFT];
                state_nxt = ST_MRD;
                if (in_mode == MODE_USED) begin
                  sum = {1'b0, cnt_r} + {1'b0, kf};
                  if (cnt_r < lim) cnt_nxt = (sum > {1'b0, lim}) ? lim : sum[COUNT_W-1:0];
                end else begin
                  cnt_nxt = (cnt_r > kf) ? cnt_r - kf : '0;
                end
              end else if (in_mode == MODE_FREE) begin
                lo_nxt = '0;
                hi_nxt = COUNT_W'(1);
                val_nxt = 1'b1;
                w_nxt = '0;
                state_nxt = ST_MRD;
              end else begin
                ov_nxt = 1'b1;
                og_nxt = 1'b1;
                oa_nxt = '0;
              end
            end
            MODE_ALLOC: begin
              if (in_run_frames == 9'd0 || in_run_frames > 9'(MAX_RUN) || cnt_r >= lim ||
                  (lim - cnt_r) < {4'd0, in_run_frames}) begin
                ov_nxt = 1'b1;
                og_nxt = 1'b0;
                oa_nxt = '0;
              end else begin
                w_nxt = '0;
                sub_nxt = '0;
                run_nxt = '0;
                state_nxt = ST_SRD;
              end
            end
            default: begin
              ov_nxt = 1'b1;
              og_nxt = 1'b0;
              oa_nxt = '0;
            end
          endcase
        end
      end
      ST_SRD: begin
        mem_re = 1'b1;
        sub_nxt = '0;
        state_nxt = ST_SCHK;
      end
      ST_SCHK: begin
        if (sub_r == 2'd0 && (&mem_q_r) && ({1'b0, w_r, 5'd31} < lim)) begin
          if (w_r == WADDR_W'(NUM_WORDS - 1)) begin
            ov_nxt = 1'b1;
            og_nxt = 1'b0;
            oa_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            run_nxt = '0;
            w_nxt = w_r + WADDR_W'(1);
            state_nxt = ST_SRD;
          end
        end else if (hit) begin
          cnt_nxt = cnt_r + {4'd0, size_r};
          lo_nxt = hit_lo;
          hi_nxt = {1'b0, hit_f} + COUNT_W'(1);
          val_nxt = 1'b1;
          fix0_nxt = 1'b0;
          raddr_nxt = {hit_lo[FRAME_W-1:0], 12'd0};
          w_nxt = hit_lo[FRAME_W-1:WORD_SHIFT];
          state_nxt = ST_MRD;
        end else if (stop || (w_r == WADDR_W'(NUM_WORDS - 1) && sub_r == 2'd3)) begin
          ov_nxt = 1'b1;
          og_nxt = 1'b0;
          oa_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          run_nxt = run_v;
          sub_nxt = sub_r + 2'd1;
          if (sub_r == 2'd3) begin
            w_nxt = w_r + WADDR_W'(1);
            state_nxt = ST_SRD;
          end
        end
      end
      ST_MRD: begin
        mem_re = 1'b1;
        state_nxt = ST_MWR;
      end
      ST_MWR: begin
        mem_we = 1'b1;
        mem_wd = val_r ? (mem_q_r | msk) : (mem_q_r & ~msk);
        if ({({1'b0, w_r} + 8'd1), 5'd0} >= hi_r) begin
          if (fix0_r) begin
            fix0_nxt = 1'b0;
            lo_nxt = '0;
            hi_nxt = COUNT_W'(1);
            val_nxt = 1'b1;
            w_nxt = '0;
            state_nxt = ST_MRD;
          end else begin
            ov_nxt = 1'b1;
            og_nxt = 1'b1;
            oa_nxt = raddr_r;
            state_nxt = ST_IDLE;
          end
        end else begin
          w_nxt = w_r + WADDR_W'(1);
          state_nxt = ST_MRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      maxf_r <= COUNT_W'(NUM_FRAMES);
      cnt_r <= COUNT_W'(NUM_FRAMES);
      w_r <= '0;
      ov_r <= 1'b0;
      fix0_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) maxf_r <= cfg_wdata;
      cnt_r <= cnt_nxt;
      w_r <= w_nxt;
      ov_r <= ov_nxt;
      fix0_r <= fix0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sub_r <= sub_nxt;
    run_r <= run_nxt;
    size_r <= size_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    val_r <= val_nxt;
    raddr_r <= raddr_nxt;
    og_r <= og_nxt;
    oa_r <= oa_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_granted = og_r;
  assign out_run_address = oa_r;
  assign out_frames_in_use = cnt_r;

`ifndef ASSERT_OFF
  a_clr_after_rst: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("clearing pass not entered after reset");
  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_run_address == '0)
    else $error("failed result carries an address");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frames_in_use <= COUNT_W'(NUM_FRAMES))
    else $error("frame counter out of range");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");
`endif
endmodule
`default_nettype wire
